// ===== hdl/annb_pkg.sv =====
// ----------------------------------------------------------------------------
// annb_pkg
// Types, codes and helpers shared by the Annex B NAL unit splitter modules.
// ----------------------------------------------------------------------------
package annb_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int QDEPTH      = 4;
    localparam int MAXB_W      = 20;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DISCARD  = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

    localparam logic [4:0] AUD_TYPE = 5'd9;

    localparam logic       MODE_DATA  = 1'b0;
    localparam logic       MODE_FLUSH = 1'b1;

    localparam logic       REG_DROP_AUD = 1'b0;
    localparam logic       REG_MAX_NAL  = 1'b1;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic [4:0] nal_type;
        logic       first_of_nal;
        logic       last_of_nal;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [1:0]             last_idx;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic res_t make_res(logic [7:0] b, logic [4:0] t, logic first,
                                      logic last, logic [1:0] st);
        res_t r;
        r.nal_byte     = b;
        r.nal_type     = t;
        r.first_of_nal = first;
        r.last_of_nal  = last;
        r.status       = st;
        return r;
    endfunction

endpackage

// ===== hdl/annb_front.sv =====
// ----------------------------------------------------------------------------
// annb_front
// Start code scanner: tracks held zeros and the held payload byte and turns
// each accepted stream byte into a list of up to four result requests.
// ----------------------------------------------------------------------------
module annb_front #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic                  in_mode,
    input  logic [7:0]            in_byte,
    input  logic                  drop_aud,
    input  logic [annb_pkg::MAXB_W-1:0] max_nal_bytes,
    output annb_pkg::push_t       push
);
    import annb_pkg::*;

    localparam int CW = (LENGTH_BITS > MAXB_W) ? LENGTH_BITS : MAXB_W;

    logic [1:0]             zero_run_reg, zero_run_next;
    logic [7:0]             held_byte_reg, held_byte_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   held_first_reg, held_first_next;
    logic                   inside_reg, inside_next;
    logic [4:0]             type_reg, type_next;
    logic                   drop_reg, drop_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    always_comb begin
        logic                   is_zero;
        logic                   is_start;
        logic                   is_normal;
        logic                   active;
        logic                   first;
        logic [7:0]             pb;
        logic [1:0]             hst;
        logic [2:0]             n;
        res_t [MAX_RESULTS-1:0] res;

        zero_run_next   = zero_run_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        inside_next     = inside_reg;
        type_next       = type_reg;
        drop_next       = drop_reg;
        count_next      = count_reg;
        n               = 3'd0;
        res             = '0;
        active          = 1'b0;
        first           = 1'b0;
        pb              = 8'd0;
        hst             = STATUS_OK;

        is_zero   = (in_mode == MODE_DATA) && (in_byte == 8'd0);
        is_start  = (in_mode == MODE_DATA) && (in_byte == 8'd1) && (zero_run_reg >= 2'd2);
        is_normal = (in_mode == MODE_DATA) && !is_zero && !is_start;

        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (k < MAX_RESULTS - 1) begin
                active = ((in_mode == MODE_FLUSH) || is_normal) && (k < int'(zero_run_reg));
                pb     = 8'd0;
            end else begin
                active = is_normal || (is_zero && (zero_run_reg == 2'd3));
                pb     = is_normal ? in_byte : 8'd0;
            end
            if (active) begin
                if (!inside_next) begin
                    res[n[1:0]] = make_res(pb, 5'd0, 1'b0, 1'b0, STATUS_DISCARD);
                    n = n + 3'd1;
                end else begin
                    first = (count_next == '0);
                    if (first) begin
                        type_next = pb[4:0];
                        drop_next = drop_aud && (pb[4:0] == AUD_TYPE);
                    end
                    hst = (CW'(count_next) > CW'(max_nal_bytes)) ? STATUS_OVERSIZE : STATUS_OK;
                    if (!drop_next && held_valid_next) begin
                        res[n[1:0]] = make_res(held_byte_next, type_next, held_first_next,
                                               1'b0, hst);
                        n = n + 3'd1;
                    end
                    if (count_next != '1) begin
                        count_next = count_next + 1'b1;
                    end
                    if (!drop_next) begin
                        held_byte_next  = pb;
                        held_valid_next = 1'b1;
                        held_first_next = first;
                    end
                end
            end
        end

        if ((in_mode == MODE_FLUSH) || is_start) begin
            hst = (CW'(count_next) > CW'(max_nal_bytes)) ? STATUS_OVERSIZE : STATUS_OK;
            if (held_valid_next && !drop_next) begin
                res[n[1:0]] = make_res(held_byte_next, type_next, held_first_next, 1'b1, hst);
                n = n + 3'd1;
            end
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            held_byte_next  = 8'd0;
            inside_next     = is_start;
            count_next      = '0;
            drop_next       = 1'b0;
            type_next       = 5'd0;
        end

        if (is_zero) begin
            if (zero_run_reg != 2'd3) begin
                zero_run_next = zero_run_reg + 2'd1;
            end
        end else begin
            zero_run_next = 2'd0;
        end

        push.valid          = in_accept && (n != 3'd0);
        push.entry.res      = res;
        push.entry.last_idx = 2'(n - 3'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg   <= 2'd0;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            inside_reg     <= 1'b0;
            type_reg       <= 5'd0;
            drop_reg       <= 1'b0;
            count_reg      <= '0;
        end else if (in_accept) begin
            zero_run_reg   <= zero_run_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            inside_reg     <= inside_next;
            type_reg       <= type_next;
            drop_reg       <= drop_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== hdl/annb_back.sv =====
// ----------------------------------------------------------------------------
// annb_back
// Request queue and output side: stores result lists and hands them out one
// result per accepted output transfer.
// ----------------------------------------------------------------------------
module annb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  annb_pkg::push_t push,
    output logic            push_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output annb_pkg::res_t  out_res,
    output logic            out_last_of_run
);
    import annb_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    entry_t        q_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;
    logic [1:0]    sub_reg;
    entry_t        head;
    logic          pop;

    assign head            = q_reg[rd_ptr_reg];
    assign out_valid       = (count_reg != '0);
    assign out_res         = head.res[sub_reg];
    assign out_last_of_run = (sub_reg == head.last_idx);
    assign push_ready      = (count_reg != (PW+1)'(QDEPTH));
    assign pop             = out_valid && out_ready && out_last_of_run;

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            q_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_valid && out_ready) begin
                if (out_last_of_run) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    sub_reg    <= 2'd0;
                end else begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end
        end
    end

endmodule

// ===== hdl/annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex B byte stream into NAL unit payload bytes with type, marks
// and status; start codes are stripped.
// ----------------------------------------------------------------------------
// Results are stored in the registered request queue before they appear on the output.
// Throughput: one input byte per cycle while the request queue has room; each byte yields zero
// to four results, and the output drains one result per cycle while m_tready is high, from a four-entry request queue.
// Reset: synchronous active-low reset empties the queue, clears the scanner
// state and sets drop_aud to 1 and max_nal_bytes to 1048575.
module annexb_nal_unit_splitter #(
    parameter int LENGTH_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // nal_byte[7:0]
    output logic [8:0]  m_tuser,   // nal_type[4:0], first_of_nal[5], status[7:6], last_of_run[8]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import annb_pkg::*;

    logic              drop_aud_reg;
    logic [MAXB_W-1:0] max_nal_reg;
    logic              in_accept;
    logic              cfg_write;
    push_t             push;
    res_t              out_res;
    logic              out_last_of_run;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_NAL) ? 32'(max_nal_reg) : 32'(drop_aud_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_aud_reg <= 1'b1;
            max_nal_reg  <= '1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_DROP_AUD) begin
                drop_aud_reg <= pwdata[0];
            end else begin
                max_nal_reg <= pwdata[MAXB_W-1:0];
            end
        end
    end

    assign in_accept = s_tvalid && s_tready;

    annb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .in_mode       (s_tuser[0]),
        .in_byte       (s_tdata),
        .drop_aud      (drop_aud_reg),
        .max_nal_bytes (max_nal_reg),
        .push          (push)
    );

    annb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .push_ready      (s_tready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_res         (out_res),
        .out_last_of_run (out_last_of_run)
    );

    assign m_tdata = out_res.nal_byte;
    assign m_tlast = out_res.last_of_nal;
    assign m_tuser = {out_last_of_run, out_res.status, out_res.first_of_nal, out_res.nal_type};

endmodule

// ===== hdl/annb_checker.sv =====
// ----------------------------------------------------------------------------
// annb_checker
// Port-level checks for the NAL unit splitter, bound to the top level.
// ----------------------------------------------------------------------------
module annb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [8:0] m_tuser,
    input logic       m_tlast
);
    import annb_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted input");

    a_discard_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[7:6] == STATUS_DISCARD)
        |-> (m_tuser[4:0] == 5'd0) && !m_tuser[5] && !m_tlast)
        else $error("discarded byte carries NAL marks");

endmodule

bind annexb_nal_unit_splitter annb_checker u_annb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/annexb_nal_unit_splitter_test.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_test
// Self-checking bench for the Annex B NAL unit splitter. A software copy of
// the scanner predicts the payload bytes, marks and status for every
// accepted stream byte. Each result leaving the block is checked against the
// oldest prediction. Stimulus is a short directed stream followed by random
// NAL sequences with noise, under several register settings, with random
// stalls on both stream sides.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import annb_pkg::*;

    typedef struct {
        logic [7:0] nal_byte;
        logic [4:0] nal_type;
        logic       first_of_nal;
        logic       last_of_nal;
        logic [1:0] status;
        logic       last_of_run;
    } nal_out_t;

    class nal_scoreboard;
        bit        drop_aud      = 1'b1;
        bit [19:0] max_nal_bytes = 20'hFFFFF;
        bit [1:0]  zero_run;
        bit [7:0]  held_byte;
        bit        held_valid;
        bit        held_first;
        bit        inside_nal;
        bit [4:0]  cur_type;
        bit        dropping;
        bit [19:0] payload_count;
        nal_out_t  expected_out[$];
        nal_out_t  step_out[$];
        int        errors;

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_DROP_AUD) begin
                drop_aud = value[0];
            end else begin
                max_nal_bytes = value[19:0];
            end
        endfunction

        function void add_result(bit [7:0] b, bit [4:0] t, bit first, bit last,
                                 bit [1:0] st);
            nal_out_t r;
            r.nal_byte     = b;
            r.nal_type     = t;
            r.first_of_nal = first;
            r.last_of_nal  = last;
            r.status       = st;
            r.last_of_run  = 1'b0;
            step_out.push_back(r);
        endfunction

        function bit [1:0] size_status();
            return (payload_count > max_nal_bytes) ? STATUS_OVERSIZE : STATUS_OK;
        endfunction

        function void give_payload(bit [7:0] b);
            bit first;
            if (!inside_nal) begin
                add_result(b, 5'd0, 1'b0, 1'b0, STATUS_DISCARD);
                return;
            end
            first = (payload_count == 0);
            if (first) begin
                cur_type = b[4:0];
                dropping = drop_aud && (cur_type == AUD_TYPE);
            end
            if (!dropping && held_valid)
                add_result(held_byte, cur_type, held_first, 1'b0, size_status());
            if (payload_count != '1)
                payload_count++;
            if (dropping)
                return;
            held_byte  = b;
            held_valid = 1'b1;
            held_first = first;
        endfunction

        function void release_held();
            if (held_valid && !dropping)
                add_result(held_byte, cur_type, held_first, 1'b1, size_status());
            held_valid = 1'b0;
            held_first = 1'b0;
            held_byte  = 8'd0;
        endfunction

        function void open_nal();
            payload_count = 0;
            dropping      = 1'b0;
            cur_type      = 5'd0;
        endfunction

        function void note_byte(logic mode, logic [7:0] b);
            step_out.delete();
            if (mode == MODE_FLUSH) begin
                repeat (zero_run) give_payload(8'd0);
                zero_run = 0;
                release_held();
                inside_nal = 1'b0;
                open_nal();
            end else if (b == 8'd0) begin
                if (zero_run < 3)
                    zero_run++;
                else
                    give_payload(8'd0);
            end else if (b == 8'd1 && zero_run >= 2) begin
                release_held();
                zero_run   = 0;
                inside_nal = 1'b1;
                open_nal();
            end else begin
                repeat (zero_run) give_payload(8'd0);
                zero_run = 0;
                give_payload(b);
            end
            if (step_out.size() > 0)
                step_out[step_out.size()-1].last_of_run = 1'b1;
            foreach (step_out[i])
                expected_out.push_back(step_out[i]);
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(nal_out_t got);
            nal_out_t e;
            if (expected_out.size() == 0) begin
                $error("unexpected result: nal_byte 0x%0h status %0d",
                       got.nal_byte, got.status);
                errors++;
                return;
            end
            e = expected_out.pop_front();
            compare_field("nal_byte", e.nal_byte, got.nal_byte);
            compare_field("nal_type", e.nal_type, got.nal_type);
            compare_field("first_of_nal", e.first_of_nal, got.first_of_nal);
            compare_field("last_of_nal", e.last_of_nal, got.last_of_nal);
            compare_field("status", e.status, got.status);
            compare_field("last_of_run", e.last_of_run, got.last_of_run);
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [8:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    nal_scoreboard sb;
    bit tx_calm    = 1'b0;
    bit rx_calm    = 1'b0;
    bit vary_idle  = 1'b1;
    int sent       = 0;
    int idle_cycles = 0;
    int rx_hold    = 0;

    annexb_nal_unit_splitter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 1;
        else if (r < 90)
            return $urandom_range(2, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin : rx_side
        if (rx_calm) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold  <= gap_len() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin : monitor
        nal_out_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.nal_byte     = m_tdata;
                got.nal_type     = m_tuser[4:0];
                got.first_of_nal = m_tuser[5];
                got.last_of_nal  = m_tlast;
                got.status       = m_tuser[7:6];
                got.last_of_run  = m_tuser[8];
                sb.check_result(got);
            end
            if (s_tvalid && s_tready)
                sb.note_byte(s_tuser[0], s_tdata);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("annexb_nal_unit_splitter_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic mode, logic [7:0] b);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 99) < 35)
            gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_out.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        mask = (idx == REG_DROP_AUD) ? 32'h0000_0001 : 32'h000F_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        sb.compare_field("register readback", value & mask, readback & mask);
    endtask

    task automatic send_payload_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_item(MODE_DATA, 8'h00);
        else if (r < 35)
            send_item(MODE_DATA, 8'h01);
        else if (r < 40)
            send_item(MODE_DATA, 8'h03);
        else
            send_item(MODE_DATA, 8'($urandom_range(0, 255)));
    endtask

    // One well-formed NAL with random content, or a burst of noise.
    task automatic send_nal();
        int unsigned r;
        int zeros;
        int len;
        if (vary_idle) begin
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4)) send_payload_byte();
            if ($urandom_range(0, 1) == 0) begin
                send_item(MODE_DATA, 8'h00);
                send_item(MODE_DATA, 8'h01);
            end
            return;
        end
        r = $urandom_range(0, 9);
        zeros = (r < 5) ? 2 : (r < 8) ? 3 : $urandom_range(4, 6);
        repeat (zeros) send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'h01);
        if ($urandom_range(0, 3) == 0)
            send_item(MODE_DATA, {3'($urandom_range(0, 7)), AUD_TYPE});
        else
            send_item(MODE_DATA, 8'($urandom_range(0, 255)));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        repeat (len) send_payload_byte();
        if ($urandom_range(0, 9) == 0)
            send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_phase(int n);
        int target;
        target = sent + n;
        while (sent < target) send_nal();
    endtask

    initial begin
        logic [8:0] opening[$];
        sb = new();
        opening = '{
            {MODE_DATA, 8'hFF}, {MODE_DATA, 8'h00}, {MODE_DATA, 8'h00},
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h01},
            {MODE_DATA, 8'h65}, {MODE_DATA, 8'h00}, {MODE_DATA, 8'h00},
            {MODE_DATA, 8'h80},
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h00}, {MODE_DATA, 8'h00},
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h01},
            {MODE_DATA, 8'h09}, {MODE_DATA, 8'hF0}, {MODE_DATA, 8'h00},
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h01},
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h00}, {MODE_DATA, 8'h01},
            {MODE_DATA, 8'h67}, {MODE_DATA, 8'h00}, {MODE_FLUSH, 8'h00}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i])
            send_item(opening[i][8], opening[i][7:0]);
        settle();

        write_reg(REG_DROP_AUD, 32'hFFFF_FFFE);
        write_reg(REG_MAX_NAL, 32'hFFF0_0001);
        random_phase(76);
        settle();

        vary_idle = 1'b0;
        tx_calm   = 1'b1;
        rx_calm   = 1'b1;
        write_reg(REG_DROP_AUD, 32'h0000_0001);
        write_reg(REG_MAX_NAL, 32'h000F_FFFF);
        random_phase(76);
        settle();

        vary_idle = 1'b1;
        tx_calm   = 1'b0;
        rx_calm   = 1'b0;
        write_reg(REG_DROP_AUD, 32'h0000_0000);
        write_reg(REG_MAX_NAL, 32'($urandom_range(2, 40)));
        random_phase(76);
        settle();

        write_reg(REG_DROP_AUD, 32'h0000_0001);
        write_reg(REG_MAX_NAL, 32'h0000_0003);
        random_phase(76);
        settle();
        repeat (16) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("annexb_nal_unit_splitter_test: clean");
        end else begin
            $display("annexb_nal_unit_splitter_test: errors");
        end
        $finish;
    end

endmodule
